// File: sv/iq_rms_level_meter_defines.svh
// ----------------------------------------------------------------------------
// iq_rms_level_meter_defines
// Assertion macros used by the level meter RTL.
// ----------------------------------------------------------------------------
`ifndef IQ_RMS_LEVEL_METER_DEFINES_SVH
`define IQ_RMS_LEVEL_METER_DEFINES_SVH

// Property checked at every clock while out of reset.
`define IQRMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define IQRMS_ASSERT_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/iqrms_pkg.sv
// ----------------------------------------------------------------------------
// iqrms_pkg
// Shared constants and types of the I/Q RMS level meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iqrms_pkg;

    localparam int CHANNELS   = 4;
    localparam int CH_W       = 4;
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 48;
    localparam int TALLY_W    = 16;
    localparam int LEVEL_W    = 16;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int ENTRY_W    = SUM_W + TALLY_W;
    localparam int ADDR_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int STEP_W     = $clog2(SUM_W + 1);

    localparam logic [15:0] THRESHOLD_RESET = 16'd2400;
    localparam logic [2:0]  ADDR_THRESHOLD  = 3'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DIV,
        ST_SQRT,
        ST_OUT
    } state_t;

endpackage

// File: sv/iqrms_ram.sv
// ----------------------------------------------------------------------------
// iqrms_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iqrms_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/iq_rms_level_meter.sv
// ----------------------------------------------------------------------------
// iq_rms_level_meter
// Per-channel RMS level meter for complex Q1.15 I/Q samples.
// ----------------------------------------------------------------------------
// Input channel (s_*): one I/Q sample per transaction with its channel number
// and a packet-end mark. Channels outside 1..CHANNELS are dropped.
// Each valid sample adds I*I+Q*Q to the channel sum and bumps its tally; the
// per-channel state sits in a single RAM entry (sum and tally).
// Each sample passes through RAM read, multiply, accumulate and write back.
// On a packet end with the tally at or above sample_threshold, the mean is
// formed by a 48-step restoring divider and the root by a 24-step digit
// recurrence, one step per cycle. The result (m_*) goes to an output
// register; the next sample is accepted while it waits. If the receiver
// stalls, a further result holds in the datapath and input is held off until
// the register frees. Reset clears all channel sums and tallies at once
// through per-entry valid bits and sets sample_threshold to 2400. The
// threshold is written over APB at byte address 0; pready is always high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "iq_rms_level_meter_defines.svh"

module iq_rms_level_meter
    import iqrms_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [CH_W-1:0]            s_channel,
    input  logic signed [SAMPLE_W-1:0] s_in_phase,
    input  logic signed [SAMPLE_W-1:0] s_quadrature,
    input  logic                       s_packet_end,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [CH_W-1:0]            m_level_channel,
    output logic [LEVEL_W-1:0]         m_rms_level,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    state_t state_reg, state_next;

    logic [15:0]                thr_reg;
    logic [CHANNELS-1:0]        vld_reg;
    logic                       rd_vld_reg;
    logic [CH_W-1:0]            ch_reg;
    logic [ADDR_W-1:0]          idx_reg;
    logic signed [SAMPLE_W-1:0] i_reg, q_reg;
    logic                       last_reg;
    logic [2*SAMPLE_W-1:0]      pi_reg, pq_reg;
    logic [ENTRY_W-1:0]         ent_reg;

    logic [SUM_W-1:0]           wrk_reg, wrk_next;
    logic [TALLY_W:0]           rem_reg, rem_next;
    logic [TALLY_W-1:0]         div_reg, div_next;
    logic [ROOT_W+1:0]          srem_reg, srem_next;
    logic [ROOT_W-1:0]          root_reg, root_next;
    logic [STEP_W-1:0]          step_reg, step_next;

    logic                       m_valid_reg;
    logic [CH_W-1:0]            m_ch_reg;
    logic [LEVEL_W-1:0]         m_lvl_reg;

    logic                       in_fire, ch_ok, cfg_wr, out_load;
    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_addr;
    logic [ENTRY_W-1:0]         ram_wdata, ram_rdata;
    logic [ADDR_W-1:0]          in_idx;

    logic signed [2*SAMPLE_W-1:0] pi_prod, pq_prod;
    logic [SUM_W:0]             sum_add;
    logic [SUM_W-1:0]           sum_new;
    logic [TALLY_W-1:0]         tally_new;
    logic                       emit;
    logic [TALLY_W:0]           rem_sh;
    logic [ROOT_W+1:0]          srem_sh, trial;
    logic [LEVEL_W-1:0]         root_sat;

    assign in_idx  = ADDR_W'(s_channel - CH_W'(1));
    assign ch_ok   = (s_channel != '0) && (s_channel <= CH_W'(CHANNELS));
    assign s_ready = (state_reg == ST_IDLE);
    assign in_fire = s_valid && s_ready;
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign prdata  = (paddr == ADDR_THRESHOLD) ? {16'd0, thr_reg} : 32'd0;

    iqrms_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CHANNELS)
    ) u_state_ram (
        .aclk (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    // full-width signed squares
    assign pi_prod = i_reg * i_reg;
    assign pq_prod = q_reg * q_reg;

    // accumulate
    assign sum_add   = {1'b0, ent_reg[ENTRY_W-1:TALLY_W]}
                     + (SUM_W+1)'(pi_reg) + (SUM_W+1)'(pq_reg);
    assign sum_new   = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    assign tally_new = (ent_reg[TALLY_W-1:0] == {TALLY_W{1'b1}})
                     ? ent_reg[TALLY_W-1:0] : ent_reg[TALLY_W-1:0] + TALLY_W'(1);
    assign emit      = last_reg && (tally_new >= thr_reg);

    // one divider step and one root step
    assign rem_sh  = {rem_reg[TALLY_W-1:0], wrk_reg[SUM_W-1]};
    assign srem_sh = {srem_reg[ROOT_W-1:0], wrk_reg[SUM_W-1:SUM_W-2]};
    assign trial   = {root_reg, 2'b01};
    assign root_sat = (|root_reg[ROOT_W-1:LEVEL_W]) ? {LEVEL_W{1'b1}}
                                                     : root_reg[LEVEL_W-1:0];
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        ram_we     = 1'b0;
        ram_addr   = idx_reg;
        ram_wdata  = {sum_new, tally_new};
        wrk_next   = wrk_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        srem_next  = srem_reg;
        root_next  = root_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                ram_addr = in_idx;
                if (in_fire && ch_ok) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                ram_we = 1'b1;
                if (emit) begin
                    ram_wdata  = '0;
                    wrk_next   = sum_new;
                    div_next   = tally_new;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (rem_sh >= {1'b0, div_reg}) begin
                    rem_next = rem_sh - {1'b0, div_reg};
                    wrk_next = {wrk_reg[SUM_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    wrk_next = {wrk_reg[SUM_W-2:0], 1'b0};
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    srem_next  = '0;
                    root_next  = '0;
                    step_next  = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                wrk_next = {wrk_reg[SUM_W-3:0], 2'b00};
                if (srem_sh >= trial) begin
                    srem_next = srem_sh - trial;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    srem_next = srem_sh;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(ROOT_W - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            thr_reg     <= THRESHOLD_RESET;
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr && paddr == ADDR_THRESHOLD) begin
                thr_reg <= pwdata[15:0];
            end
            if (ram_we) begin
                vld_reg[idx_reg] <= 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            ch_reg     <= s_channel;
            idx_reg    <= in_idx;
            i_reg      <= s_in_phase;
            q_reg      <= s_quadrature;
            last_reg   <= s_packet_end;
            rd_vld_reg <= vld_reg[in_idx];
        end
        if (state_reg == ST_MUL) begin
            pi_reg  <= unsigned'(pi_prod);
            pq_reg  <= unsigned'(pq_prod);
            ent_reg <= rd_vld_reg ? ram_rdata : '0;
        end
        wrk_reg  <= wrk_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
        step_reg <= step_next;
        if (out_load) begin
            m_ch_reg  <= ch_reg;
            m_lvl_reg <= root_sat;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_level_channel = m_ch_reg;
    assign m_rms_level     = m_lvl_reg;

    `IQRMS_ASSERT_NEXT(a_drop_bad_channel, in_fire && !ch_ok, s_ready,
        "dropped transaction did not return to idle")
    `IQRMS_ASSERT(a_out_channel_range,
        !out_load || (ch_reg != '0 && ch_reg <= CH_W'(CHANNELS)),
        "result for a channel out of range")
    `IQRMS_ASSERT_NEXT(a_clear_on_emit, state_reg == ST_ACC && emit,
        state_reg == ST_DIV && vld_reg[idx_reg],
        "emitting sample did not start the divider")

endmodule

// File: verif/iq_rms_level_meter_tb.sv
// ----------------------------------------------------------------------------
// iq_rms_level_meter_tb
// Self-checking testbench of the per-channel I/Q RMS level meter.
// ----------------------------------------------------------------------------
// Drives I/Q samples over the s_ channel with random gaps and consumes levels
// on the m_ channel with random stalls. Every accepted sample is run through a
// behavioral level predictor (per-channel power sum and sample tally), and each
// level transaction is compared with the oldest predicted level. Covers the
// reset threshold, sample extremes, dropped channels, zero and unreachable
// thresholds, a long output stall, and random packet traffic over several
// threshold settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iq_rms_level_meter_tb;
    import iqrms_pkg::*;

    typedef struct {
        logic [CH_W-1:0]    chan;
        logic [LEVEL_W-1:0] level;
    } level_t;

    localparam logic [SUM_W-1:0]   SUM_SAT   = {SUM_W{1'b1}};
    localparam logic [TALLY_W-1:0] TALLY_SAT = {TALLY_W{1'b1}};
    localparam int DRAIN_CYCLES = 120;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [CH_W-1:0]            s_channel = '0;
    logic signed [SAMPLE_W-1:0] s_in_phase = '0;
    logic signed [SAMPLE_W-1:0] s_quadrature = '0;
    logic                       s_packet_end = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [CH_W-1:0]            m_level_channel;
    logic [LEVEL_W-1:0]         m_rms_level;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [2:0]                 paddr = '0;
    logic [31:0]                pwdata = '0;
    logic [31:0]                prdata;
    logic                       pready;

    level_t         pending_levels[$];
    logic [SUM_W-1:0]   chan_power[CHANNELS];
    logic [TALLY_W-1:0] chan_tally[CHANNELS];
    logic [15:0]    threshold_shadow = THRESHOLD_RESET;

    bit  src_calm = 1'b0;
    bit  sink_calm = 1'b0;
    int  hold_request = 0;
    int  hold_left = 0;
    int  errors = 0;
    int  samples_sent = 0;
    int  levels_seen = 0;

    iq_rms_level_meter i_dut (.*);

    always #4 aclk = ~aclk;

    initial begin
        #20_000_000;
        $display("FAIL iq_rms_level_meter");
        $finish;
    end

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void predict_level(logic [CH_W-1:0] ch, logic signed [15:0] i_s,
                                          logic signed [15:0] q_s, logic last);
        int unsigned idx;
        longint unsigned mag;
        longint unsigned total;
        longint unsigned root;
        level_t lv;
        if (ch < 1 || ch > CHANNELS) return;
        idx = ch - 1;
        mag = longint'(i_s) * longint'(i_s) + longint'(q_s) * longint'(q_s);
        total = longint'(chan_power[idx]) + mag;
        chan_power[idx] = (total > longint'(SUM_SAT)) ? SUM_SAT : total[SUM_W-1:0];
        if (chan_tally[idx] != TALLY_SAT) chan_tally[idx]++;
        if (!last || chan_tally[idx] < threshold_shadow) return;
        root = isqrt(longint'(chan_power[idx]) / longint'(chan_tally[idx]));
        if (root > 64'hFFFF) root = 64'hFFFF;
        lv.chan = ch;
        lv.level = root[LEVEL_W-1:0];
        pending_levels.push_back(lv);
        chan_power[idx] = '0;
        chan_tally[idx] = '0;
    endfunction

    // result checker
    always @(posedge aclk) begin
        level_t exp_lv;
        if (aresetn && m_valid && m_ready) begin
            levels_seen++;
            if (pending_levels.size() == 0) begin
                errors++;
                $display("%0t: unexpected level transaction ch=%0d level=%0d",
                         $realtime, m_level_channel, m_rms_level);
            end else begin
                exp_lv = pending_levels.pop_front();
                if (exp_lv.chan !== m_level_channel) begin
                    errors++;
                    $display("%0t: level_channel expected %0d actual %0d",
                             $realtime, exp_lv.chan, m_level_channel);
                end
                if (exp_lv.level !== m_rms_level) begin
                    errors++;
                    $display("%0t: rms_level expected %0d actual %0d",
                             $realtime, exp_lv.level, m_rms_level);
                end
            end
        end
    end

    // receiver ready, with long hold-off on request
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (sink_calm) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 28);
        end
    end

    task automatic send_sample(logic [CH_W-1:0] ch, logic [15:0] i_s, logic [15:0] q_s,
                               logic last);
        while (!src_calm && $urandom_range(99) < 28) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_channel    <= ch;
        s_in_phase   <= i_s;
        s_quadrature <= q_s;
        s_packet_end <= last;
        do @(posedge aclk); while (!s_ready);
        predict_level(ch, i_s, q_s, last);
        samples_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(logic wr, logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_THRESHOLD;
        pwdata  <= {16'h0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (!wr && prdata[15:0] !== value) begin
            errors++;
            $display("%0t: threshold readback expected %0d actual %0d",
                     $realtime, value, prdata[15:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_threshold(logic [15:0] value);
        wait_drained();
        apb_access(1'b1, value);
        threshold_shadow = value;
        apb_access(1'b0, value);
    endtask

    task automatic test_reset_threshold();
        apb_access(1'b0, THRESHOLD_RESET);
        for (int n = 0; n < 24; n++)
            send_sample(2, 16'($urandom), 16'($urandom), n % 8 == 7);
    endtask

    task automatic test_extremes();
        set_threshold(16'd1);
        send_sample(1, 16'h7FFF, 16'h7FFF, 1'b1);
        send_sample(2, 16'h8000, 16'h8000, 1'b1);
        send_sample(3, 16'h0000, 16'h0000, 1'b1);
        send_sample(4, 16'h8000, 16'h7FFF, 1'b1);
        send_sample(1, 16'hFFFF, 16'h0001, 1'b1);
        send_sample(0, 16'h7FFF, 16'h8000, 1'b1);
        send_sample(5, 16'h1234, 16'h4321, 1'b1);
        send_sample(15, 16'hFFFF, 16'hFFFF, 1'b1);
        send_sample(2, 16'h4000, 16'hC000, 1'b0);
        send_sample(2, 16'h0100, 16'h0000, 1'b0);
        send_sample(2, 16'h0000, 16'hFF00, 1'b1);
        set_threshold(16'd0);
        send_sample(3, 16'h0005, 16'hFFFB, 1'b1);
        send_sample(4, 16'h8000, 16'h0000, 1'b0);
        send_sample(4, 16'h0000, 16'h0000, 1'b1);
        set_threshold(16'd32768);
        for (int n = 0; n < 6; n++)
            send_sample(CH_W'(1 + n % CHANNELS), 16'($urandom), 16'($urandom), 1'b1);
    endtask

    task automatic test_output_stall();
        set_threshold(16'd1);
        hold_request = 400;
        for (int n = 0; n < 40; n++)
            send_sample(CH_W'($urandom_range(1, CHANNELS)), 16'($urandom),
                        16'($urandom), 1'b1);
    endtask

    task automatic random_phase(logic [15:0] thr, int n_items, bit calm);
        int sent;
        int len;
        logic [CH_W-1:0] ch;
        set_threshold(thr);
        src_calm = calm;
        sink_calm = calm;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 82) begin
                ch = CH_W'($urandom_range(1, CHANNELS));
                len = (thr <= 16) ? $urandom_range(1, thr + 2) : $urandom_range(1, 20);
                for (int n = 0; n < len; n++)
                    send_sample(ch, 16'($urandom), 16'($urandom), n == len - 1);
                sent += len;
            end else begin
                send_sample(CH_W'($urandom_range(0, 15)), 16'($urandom), 16'($urandom),
                            1'($urandom_range(1)));
                sent++;
            end
        end
        src_calm = 1'b0;
        sink_calm = 1'b0;
    endtask

    task automatic test_random_traffic();
        random_phase(16'd1, 150, 1'b0);
        random_phase(16'd2, 150, 1'b0);
        random_phase(16'd3, 200, 1'b1);
        random_phase(16'd5, 200, 1'b0);
        random_phase(16'd8, 150, 1'b0);
        random_phase(16'd16, 200, 1'b0);
        random_phase(16'd32768, 100, 1'b0);
        random_phase(16'd1, 60, 1'b0);
    endtask

    initial begin
        for (int k = 0; k < CHANNELS; k++) begin
            chan_power[k] = '0;
            chan_tally[k] = '0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_threshold();
        test_extremes();
        test_output_stall();
        test_random_traffic();
        wait_drained();
        $display("Covered %0d samples and %0d level transactions over thresholds 0..32768,",
                 samples_sent, levels_seen);
        $display("dropped channels, sample extremes and a long output stall.");
        if (errors == 0)
            $display("PASS iq_rms_level_meter");
        else
            $display("FAIL iq_rms_level_meter");
        $finish;
    end

endmodule
